// ===== hw/rtl/isbn10_hyphenated_validator_defines.svh =====
// Assertion helpers for the ISBN-10 validator; compiled out under SYNTHESIS.
`ifndef ISBN10_HYPHENATED_VALIDATOR_DEFINES_SVH
`define ISBN10_HYPHENATED_VALIDATOR_DEFINES_SVH

`ifndef SYNTHESIS
`define ISBNV_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("isbnv: same-cycle check failed");
`define ISBNV_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("isbnv: next-cycle check failed");
`else
`define ISBNV_ASSERT_IMP(label, ante, cons)
`define ISBNV_ASSERT_NXT(label, ante, cons)
`endif

`endif

// ===== hw/rtl/isbnv_pkg.sv =====
package isbnv_pkg;

	localparam int unsigned CHAR_W  = 8;
	localparam int unsigned POS_W   = 4;
	localparam int unsigned HCNT_W  = 3;
	localparam int unsigned GRP_W   = 4;
	localparam int unsigned WGT_W   = 4;
	localparam int unsigned SUM_W   = 9;
	localparam int unsigned TOTAL_W = SUM_W + 1;

	localparam logic [POS_W-1:0]  LAST_POS         = POS_W'(12);
	localparam logic [POS_W-1:0]  THIRD_HYPHEN_POS = POS_W'(11);
	localparam logic [POS_W-1:0]  POS_MAX          = '1;
	localparam logic [HCNT_W-1:0] HCNT_MAX         = '1;
	localparam logic [HCNT_W-1:0] HYPHENS_NEEDED   = HCNT_W'(3);
	localparam logic [GRP_W-1:0]  GRP_MAX          = '1;
	localparam logic [GRP_W-1:0]  MAX_GROUP1       = GRP_W'(5);
	localparam logic [GRP_W-1:0]  MAX_GROUP2       = GRP_W'(7);
	localparam logic [GRP_W-1:0]  MAX_GROUP3       = GRP_W'(6);
	localparam logic [WGT_W-1:0]  START_WEIGHT     = WGT_W'(10);
	localparam logic [WGT_W:0]    X_VALUE          = (WGT_W+1)'(10);

	localparam logic [CHAR_W-1:0] CHAR_ZERO   = 8'h30;
	localparam logic [CHAR_W-1:0] CHAR_NINE   = 8'h39;
	localparam logic [CHAR_W-1:0] CHAR_HYPHEN = 8'h2D;
	localparam logic [CHAR_W-1:0] CHAR_X      = 8'h58;

	typedef struct packed {
		logic [CHAR_W-1:0] code;
		logic              last;
	} item_t;

	typedef struct packed {
		logic done;   // last character consumed this cycle
		logic valid;  // verdict for that string
	} verdict_t;

endpackage

// ===== hw/rtl/isbn10_hyphenated_validator.sv =====
// The verdict word passes through the input register, then the output register.
// Throughput: one character word per cycle; a held verdict stalls input only
//   when the next last character reaches the input register.
// Reset: arst_n clears the input register, all string state and the output
//   register at once; no sweep is needed.
`include "isbn10_hyphenated_validator_defines.svh"

module isbn10_hyphenated_validator (
	input  logic       clk,
	input  logic       arst_n,
	// character stream
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] char_code
	input  logic       s_tlast,   // last_char
	// verdict stream, one word per string
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata    // [0] isbn_valid, [7:1] zero
);
	import isbnv_pkg::*;

	// Stage 1: input register holding one character word.
	item_t    item_s1;
	logic     valid_s1;
	logic     consume;
	logic     s_fire;
	verdict_t verdict;

	// Output register.
	logic out_valid_q;
	logic out_data_q;

	// A non-last character never needs the output slot, so it always drains.
	// A last character drains when the verdict register is free or emptying.
	assign consume  = valid_s1 && (!item_s1.last || !out_valid_q || m_tready);
	assign s_tready = !valid_s1 || consume;
	assign s_fire   = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_fire) begin
			valid_s1 <= 1'b1;
		end else if (consume) begin
			valid_s1 <= 1'b0;
		end
	end

	// payload, no reset needed
	always_ff @(posedge clk) begin
		if (s_fire) begin
			item_s1.code <= s_tdata;
			item_s1.last <= s_tlast;
		end
	end

	// All counters, the weighted sum and the mod-11 check live here.
	isbnv_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.fire    (consume),
		.item    (item_s1),
		.verdict (verdict)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (verdict.done) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (verdict.done)
			out_data_q <= verdict.valid;
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {7'b0, out_data_q};

	// Checks
	`ISBNV_ASSERT_NXT(a_verdict_loaded, verdict.done, m_tvalid)
	`ISBNV_ASSERT_NXT(a_accept_fills_s1, s_fire, valid_s1)
	`ISBNV_ASSERT_IMP(a_empty_s1_ready, !valid_s1, s_tready)
	`ISBNV_ASSERT_IMP(a_no_overwrite, verdict.done && out_valid_q, m_tready)

endmodule

// ===== hw/rtl/isbnv_mod11.sv =====
module isbnv_mod11 (
	input  logic [isbnv_pkg::TOTAL_W-1:0] total,
	output logic                          multiple
);
	import isbnv_pkg::*;

	// floor(x/11) ~ (x*93)>>10, low by at most one for 10-bit x
	localparam int unsigned RECIP   = 93;
	localparam int unsigned SHIFT   = 10;
	localparam int unsigned PROD_W  = TOTAL_W + 7;
	localparam int unsigned QUOT_W  = PROD_W - SHIFT;
	localparam int unsigned MODULUS = 11;

	logic [PROD_W-1:0]  prod;
	logic [QUOT_W-1:0]  quot;
	logic [TOTAL_W-1:0] rem;

	always_comb begin
		prod     = PROD_W'(total) * PROD_W'(RECIP);
		quot     = prod[PROD_W-1:SHIFT];
		rem      = total - TOTAL_W'(TOTAL_W'(quot) * TOTAL_W'(MODULUS));
		multiple = (rem == '0) || (rem == TOTAL_W'(MODULUS));
	end

endmodule

// ===== hw/rtl/isbnv_core.sv =====
module isbnv_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               fire,
	input  isbnv_pkg::item_t   item,
	output isbnv_pkg::verdict_t verdict
);
	import isbnv_pkg::*;

	logic [POS_W-1:0]  pos_q, pos_d;
	logic [HCNT_W-1:0] hcnt_q, hcnt_d, hcnt_inc;
	logic [GRP_W-1:0]  grp_q, grp_d, grp_inc;
	logic [WGT_W-1:0]  wgt_q, wgt_d;
	logic [SUM_W-1:0]  sum_q, sum_d;
	logic              prev_hyp_q, prev_hyp_d;
	logic              err_q, err_d;

	logic               is_digit, is_hyphen, is_x;
	logic [2*WGT_W-1:0] prod;
	logic [WGT_W:0]     check_val;
	logic [TOTAL_W-1:0] total;
	logic               multiple;
	logic               ok;

	isbnv_mod11 u_mod11 (
		.total    (total),
		.multiple (multiple)
	);

	always_comb begin
		is_digit  = (item.code >= CHAR_ZERO) && (item.code <= CHAR_NINE);
		is_hyphen = (item.code == CHAR_HYPHEN);
		is_x      = (item.code == CHAR_X);
		prod      = {{WGT_W{1'b0}}, item.code[3:0]} * {{WGT_W{1'b0}}, wgt_q};
		hcnt_inc  = (hcnt_q != HCNT_MAX) ? hcnt_q + HCNT_W'(1) : hcnt_q;
		grp_inc   = (grp_q != GRP_MAX) ? grp_q + GRP_W'(1) : grp_q;

		if (is_digit)
			check_val = {1'b0, item.code[3:0]};
		else if (is_x)
			check_val = X_VALUE;
		else
			check_val = '0;
		total = TOTAL_W'(sum_q) + TOTAL_W'(check_val);

		ok = (pos_q == LAST_POS) && !err_q && (hcnt_q == HYPHENS_NEEDED) &&
			(is_digit || is_x) && multiple;

		pos_d      = (pos_q != POS_MAX) ? pos_q + POS_W'(1) : pos_q;
		hcnt_d     = hcnt_q;
		grp_d      = grp_q;
		wgt_d      = wgt_q;
		sum_d      = sum_q;
		prev_hyp_d = prev_hyp_q;
		err_d      = err_q;

		if (item.last) begin
			pos_d      = '0;
			hcnt_d     = '0;
			grp_d      = '0;
			wgt_d      = START_WEIGHT;
			sum_d      = '0;
			prev_hyp_d = 1'b0;
			err_d      = 1'b0;
		end else if (pos_q >= LAST_POS) begin
			err_d = 1'b1;   // too long
		end else if (is_hyphen) begin
			hcnt_d     = hcnt_inc;
			grp_d      = '0;
			prev_hyp_d = 1'b1;
			if ((pos_q == '0) || prev_hyp_q)
				err_d = 1'b1;
			if ((hcnt_inc == HCNT_W'(1)) && (grp_q > MAX_GROUP1))
				err_d = 1'b1;
			if ((hcnt_inc == HCNT_W'(2)) && (grp_q > MAX_GROUP2))
				err_d = 1'b1;
			if ((hcnt_inc == HYPHENS_NEEDED) &&
				((grp_q > MAX_GROUP3) || (pos_q != THIRD_HYPHEN_POS)))
				err_d = 1'b1;
			if (hcnt_inc > HYPHENS_NEEDED)
				err_d = 1'b1;
		end else if (is_digit) begin
			grp_d      = grp_inc;
			sum_d      = sum_q + SUM_W'(prod);
			wgt_d      = (wgt_q != '0) ? wgt_q - WGT_W'(1) : wgt_q;
			prev_hyp_d = 1'b0;
		end else begin
			grp_d      = grp_inc;
			prev_hyp_d = 1'b0;
			err_d      = 1'b1;
		end

		verdict.done  = fire && item.last;
		verdict.valid = ok;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q      <= '0;
			hcnt_q     <= '0;
			grp_q      <= '0;
			wgt_q      <= START_WEIGHT;
			sum_q      <= '0;
			prev_hyp_q <= 1'b0;
			err_q      <= 1'b0;
		end else if (fire) begin
			pos_q      <= pos_d;
			hcnt_q     <= hcnt_d;
			grp_q      <= grp_d;
			wgt_q      <= wgt_d;
			sum_q      <= sum_d;
			prev_hyp_q <= prev_hyp_d;
			err_q      <= err_d;
		end
	end

endmodule

// ===== verif/isbn10_verdict_checker.sv =====
`timescale 1ns / 100ps

// Watches both streams, folds each accepted character into a private copy of
// the validator state and compares every verdict word with the oldest
// expectation.
module isbn10_verdict_checker (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	input  logic              s_tready,
	input  logic [7:0]        s_tdata,
	input  logic              s_tlast,
	input  logic              m_tvalid,
	input  logic              m_tready,
	input  logic [7:0]        m_tdata,
	output int unsigned       mismatches,
	output int unsigned       outstanding
);
	import isbnv_pkg::*;

	localparam int unsigned CHECK_MOD = 11;
	localparam int unsigned SHOWN_MAX = 10;

	logic [POS_W-1:0]  char_pos;
	logic [HCNT_W-1:0] hyphens;
	logic [GRP_W-1:0]  grp_len;
	logic [WGT_W-1:0]  weight;
	logic [SUM_W-1:0]  wsum;
	logic              prev_hyphen;
	logic              err_seen;

	logic              verdict_q[$];
	int unsigned       err_cnt;

	task automatic clear_string();
		char_pos    = '0;
		hyphens     = '0;
		grp_len     = '0;
		weight      = START_WEIGHT;
		wsum        = '0;
		prev_hyphen = 1'b0;
		err_seen    = 1'b0;
	endtask

	task automatic fold_char(input logic [7:0] code, input logic last);
		logic [POS_W-1:0] at;
		logic             is_digit;
		logic             ok;
		int unsigned      digit_val;
		at       = char_pos;
		is_digit = (code >= CHAR_ZERO) && (code <= CHAR_NINE);
		if (char_pos != POS_MAX)
			char_pos++;
		if (!last) begin
			if (at >= LAST_POS) begin
				err_seen = 1'b1;
			end else if (code == CHAR_HYPHEN) begin
				if (at == 0 || prev_hyphen)
					err_seen = 1'b1;
				if (hyphens != HCNT_MAX)
					hyphens++;
				if (hyphens == 1 && grp_len > MAX_GROUP1)
					err_seen = 1'b1;
				if (hyphens == 2 && grp_len > MAX_GROUP2)
					err_seen = 1'b1;
				if (hyphens == HYPHENS_NEEDED &&
					(grp_len > MAX_GROUP3 || at != THIRD_HYPHEN_POS))
					err_seen = 1'b1;
				if (hyphens > HYPHENS_NEEDED)
					err_seen = 1'b1;
				grp_len     = '0;
				prev_hyphen = 1'b1;
			end else begin
				if (is_digit) begin
					wsum = SUM_W'(int'(wsum) + int'(code - CHAR_ZERO) * int'(weight));
					if (weight != 0)
						weight--;
				end else begin
					err_seen = 1'b1;
				end
				if (grp_len != GRP_MAX)
					grp_len++;
				prev_hyphen = 1'b0;
			end
		end else begin
			ok = (at == LAST_POS) && !err_seen && (hyphens == HYPHENS_NEEDED);
			if (is_digit) begin
				digit_val = code - CHAR_ZERO;
			end else if (code == CHAR_X) begin
				digit_val = X_VALUE;
			end else begin
				digit_val = 0;
				ok        = 1'b0;
			end
			if (((int'(wsum) + digit_val) % CHECK_MOD) != 0)
				ok = 1'b0;
			verdict_q.push_back(ok);
			clear_string();
		end
	endtask

	task automatic flag(input string what, input logic [7:0] exp_word,
		input logic [7:0] got_word);
		err_cnt++;
		if (err_cnt <= SHOWN_MAX)
			$display("%0t: %s: expected %b, got %b", $realtime, what, exp_word, got_word);
	endtask

	always @(posedge clk or negedge arst_n) begin
		logic [7:0] exp_word;
		if (!arst_n) begin
			clear_string();
			verdict_q.delete();
			err_cnt = 0;
			mismatches  <= 0;
			outstanding <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (verdict_q.size() == 0) begin
					flag("verdict word with none pending", 8'h00, m_tdata);
				end else begin
					exp_word = {7'b0, verdict_q.pop_front()};
					if (m_tdata !== exp_word)
						flag("verdict word mismatch", exp_word, m_tdata);
				end
			end
			if (s_tvalid && s_tready)
				fold_char(s_tdata, s_tlast);
			mismatches  <= err_cnt;
			outstanding <= verdict_q.size();
		end
	end

endmodule

// ===== verif/tb_isbn10_hyphenated_validator.sv =====
`timescale 1ns / 100ps

// Top of the validator bench: makes the character stream and the verdict
// back-pressure, and gives the verdict. All prediction and comparison is done
// in the checker instantiated next to the block.
module tb_isbn10_hyphenated_validator;
	import isbnv_pkg::*;

	localparam int unsigned CHAR_TARGET = 1350;     // random characters to send
	localparam int unsigned CYCLE_LIMIT = 400000;   // hard stop, far above a slow run
	localparam int unsigned HOLD_START  = 500;      // earliest cycle for the long stall to begin
	localparam int unsigned HOLD_LEN    = 300;      // long stall, in cycles
	localparam int unsigned DRAIN_WAIT  = 8;        // settle time once no verdict is pending
	localparam int unsigned CHECK_MOD   = 11;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata  = 8'h00;   // [7:0] char_code
	logic        s_tlast  = 1'b0;    // last_char
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [7:0]  m_tdata;            // [0] isbn_valid, [7:1] zero

	int unsigned mismatches;
	int unsigned outstanding;
	int unsigned cycles     = 0;
	int unsigned chars_sent = 0;
	int unsigned burst_left = 0;

	// characters of the string being built, first character at the front
	logic [7:0]  str_q[$];

	always #10 clk = ~clk;

	isbn10_hyphenated_validator uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	isbn10_verdict_checker checker_i (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tlast     (s_tlast),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	// Watchdog: any hang, or an expected verdict that never shows up, ends here.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	// Offer one character word and hold it until the block takes it.
	// Bursts of back-to-back words, separated by random idle gaps. valid is
	// only dropped when a real gap follows, so it never toggles in one step.
	task automatic send_char(input logic [7:0] code, input logic last);
		int unsigned gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 40);
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tdata  <= code;
		s_tlast  <= last;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		chars_sent++;
	endtask

	// Whole string in str_q; last flag rides on the final character.
	task automatic send_str();
		foreach (str_q[i])
			send_char(str_q[i], i == str_q.size() - 1);
	endtask

	task automatic load_text(input string text);
		str_q.delete();
		for (int i = 0; i < text.len(); i++)
			str_q.push_back(text[i]);
	endtask

	// Half digits and hyphens, the rest 'X' and arbitrary bytes.
	function automatic logic [7:0] pick_char();
		case ($urandom_range(0, 5))
			0, 1:    return CHAR_ZERO + 8'($urandom_range(0, 9));
			2:       return CHAR_HYPHEN;
			3:       return CHAR_X;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	// Well-formed ISBN-10: group sizes within limits, third hyphen at
	// position 11, correct check digit ('X' when it comes out as ten).
	task automatic build_valid();
		int         g1, g2, g3, sum, w, chk;
		logic [7:0] d;
		do begin
			g1 = $urandom_range(1, 5);
			g2 = $urandom_range(1, 7);
			g3 = 9 - g1 - g2;
		end while (g3 < 1 || g3 > 6);
		str_q.delete();
		sum = 0;
		w   = 10;
		for (int i = 0; i < 9; i++) begin
			d = 8'($urandom_range(0, 9));
			str_q.push_back(CHAR_ZERO + d);
			sum += d * w;
			w--;
			if (i == g1 - 1 || i == g1 + g2 - 1 || i == 8)
				str_q.push_back(CHAR_HYPHEN);
		end
		chk = (CHECK_MOD - sum % CHECK_MOD) % CHECK_MOD;
		str_q.push_back(chk == 10 ? CHAR_X : CHAR_ZERO + 8'(chk));
	endtask

	// Change a well-formed string in one way: bad check, replaced character, wrong
	// length, swapped neighbours.
	task automatic mutate_str(input int unsigned how);
		int unsigned at, n;
		logic [7:0]  c;
		at = $urandom_range(0, str_q.size() - 1);
		case (how)
			0: begin   // different check character
				do c = pick_char(); while (c == str_q[str_q.size() - 1]);
				str_q[str_q.size() - 1] = c;
			end
			1: str_q[at] = pick_char();
			2: str_q.delete(at);
			3: str_q.insert(at, pick_char());
			4: begin   // too long, up to past the saturation of the position count
				n = $urandom_range(1, 7);
				repeat (n) str_q.push_back(pick_char());
			end
			5: begin
				if (at == str_q.size() - 1)
					at--;
				c             = str_q[at];
				str_q[at]     = str_q[at + 1];
				str_q[at + 1] = c;
			end
			default: begin   // too short
				n = $urandom_range(1, 12);
				while (str_q.size() > n)
					void'(str_q.pop_back());
			end
		endcase
	endtask

	// 13 characters with hyphens scattered at random: stresses the group
	// limits, adjacent hyphens and the hyphen count.
	task automatic build_layout();
		str_q.delete();
		for (int i = 0; i < 12; i++)
			str_q.push_back(($urandom_range(0, 3) == 0) ? CHAR_HYPHEN :
				CHAR_ZERO + 8'($urandom_range(0, 9)));
		str_q.push_back(($urandom_range(0, 10) == 0) ? CHAR_X :
			CHAR_ZERO + 8'($urandom_range(0, 9)));
	endtask

	task automatic build_noise();
		int unsigned n;
		n = $urandom_range(1, 18);
		str_q.delete();
		repeat (n) str_q.push_back(pick_char());
	endtask

	// Receiver: stretches of always-ready, coin-flip, periodic and sparse
	// ready, plus one long hold-off so the verdict register backs up and the
	// block stalls its character input.
	initial begin
		int unsigned mode, len;
		bit          held;
		held = 1'b0;
		wait (arst_n);
		forever begin
			mode = $urandom_range(0, 3);
			len  = $urandom_range(20, 200);
			for (int i = 0; i < len; i++) begin
				@(posedge clk);
				case (mode)
					0:       m_tready <= 1'b1;
					1:       m_tready <= 1'($urandom_range(0, 1));
					2:       m_tready <= (i % 4) != 0;
					default: m_tready <= ($urandom_range(0, 7) == 0);
				endcase
			end
			if (!held && cycles >= HOLD_START) begin
				held = 1'b1;
				@(posedge clk);
				m_tready <= 1'b0;
				repeat (HOLD_LEN) @(posedge clk);
			end
		end
	end

	// Stimulus and verdict.
	initial begin
		int unsigned sel;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: valid string with 'X' as check digit (covers 0 and 9 too)
		load_text("0-8044-2957-X");
		send_str();
		// lone characters: all-ones and all-zeros bytes, 'X', hyphen -> too short
		str_q.delete();
		str_q.push_back(8'hFF);
		send_str();
		str_q.delete();
		str_q.push_back(8'h00);
		send_str();
		load_text("X");
		send_str();
		load_text("-");
		send_str();
		// adjacent hyphens, short
		load_text("1--2");
		send_str();

		// Random: mostly well-formed strings, clean or with one defect.
		while (chars_sent < CHAR_TARGET) begin
			sel = $urandom_range(0, 99);
			if (sel < 45) begin
				build_valid();
			end else if (sel < 75) begin
				build_valid();
				mutate_str($urandom_range(0, 6));
			end else if (sel < 87) begin
				build_layout();
			end else begin
				build_noise();
			end
			send_str();
		end
		s_tvalid <= 1'b0;

		// let the checker's pending count reflect the last word first
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);

		if (mismatches == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/isbnv_pkg.sv
hw/rtl/isbnv_mod11.sv
hw/rtl/isbnv_core.sv
hw/rtl/isbn10_hyphenated_validator.sv
verif/isbn10_verdict_checker.sv
verif/tb_isbn10_hyphenated_validator.sv
